FILE: src/lsbc_pkg.sv
// Shared types, codes and blink pattern ROM for the LED status blink controller.
package lsbc_pkg;

  // Status codes in priority order, highest first
  typedef enum logic [2:0] {
    ST_ALARM   = 3'd0,
    ST_LICENSE = 3'd1,
    ST_RLY_ERR = 3'd2,
    ST_ACTIVE  = 3'd3,
    ST_WAITING = 3'd4,
    ST_NOGPS   = 3'd5,
    ST_IDLE    = 3'd6
  } status_t;

  // Blink phases; code 3 is never entered
  typedef enum logic [1:0] {
    PH_ON    = 2'd0,
    PH_OFF   = 2'd1,
    PH_PAUSE = 2'd2
  } phase_t;

  // Relay mode field codes
  localparam logic [1:0] RLY_WAITING = 2'd1;
  localparam logic [1:0] RLY_ACTIVE  = 2'd2;
  localparam logic [1:0] RLY_ERROR   = 2'd3;

  localparam int unsigned DUR_W = 13;  // widest duration is 4900 ms

  // Deadline used by the solid pattern
  localparam logic [31:0] DEADLINE_SOLID = 32'hFFFF_FFFF;

  // Deadline after reset: idle pattern armed at time 0
  localparam logic [31:0] DEADLINE_RST = 32'd100;

  typedef struct packed {
    logic [DUR_W-1:0] on_ms;
    logic [DUR_W-1:0] off_ms;
    logic [2:0]       pulses;
    logic [DUR_W-1:0] rest_ms;
    logic             solid;
  } pattern_t;

  // Input transaction
  typedef struct packed {
    logic [31:0] now_ms;
    logic        relay_valid;
    logic        relay_alarm;
    logic [1:0]  relay_mode;
    logic        relay_synced;
    logic        rental_lapsed;
    logic        gnss_3d_lock;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic       led_on;
    logic [2:0] status_code;
  } out_item_t;

  // Pattern ROM; the unused code shares the idle pattern
  function automatic pattern_t pattern_lookup(input logic [2:0] code);
    pattern_t p;
    p = '{on_ms: 13'd100, off_ms: 13'd4900, pulses: 3'd0, rest_ms: 13'd0, solid: 1'b0};
    unique case (code)
      ST_ALARM:   p = '{13'd50,  13'd50,   3'd0, 13'd0,    1'b0};
      ST_LICENSE: p = '{13'd100, 13'd150,  3'd5, 13'd3000, 1'b0};
      ST_RLY_ERR: p = '{13'd200, 13'd200,  3'd3, 13'd2000, 1'b0};
      ST_ACTIVE:  p = '{13'd100, 13'd400,  3'd0, 13'd0,    1'b0};
      ST_WAITING: p = '{13'd0,   13'd0,    3'd0, 13'd0,    1'b1};
      ST_NOGPS:   p = '{13'd600, 13'd1400, 3'd0, 13'd0,    1'b0};
      default:    p = '{13'd100, 13'd4900, 3'd0, 13'd0,    1'b0};
    endcase
    return p;
  endfunction

endpackage

FILE: src/led_status_blink_controller.sv
// Top level: status priority select and blink state machine with registered in/out.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------
//  in      | in_valid / in_stall  | in_item  (lsbc_pkg::in_item_t)
//  out     | out_valid / out_stall| out_item (lsbc_pkg::out_item_t)
//  cfg     | cfg_valid / cfg_ready| cfg_data (led_output_enable)
//
// One transaction is accepted per cycle into the input register while in_stall is low;
// its result is loaded into the result register once that register is free.
// rst_n is synchronous: idle status, ON phase, deadline 100, LED level on, output enabled.
// out_stall holds the result register; the input register keeps taking a
// transaction while the result register is free or being drained.
module led_status_blink_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lsbc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output lsbc_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);
  import lsbc_pkg::*;

  // Pipeline control
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  logic      out_free;
  logic      advance;

  // Blink machine state
  logic         enable_r;
  status_t      status_r,   status_nxt;
  phase_t       phase_r,    phase_nxt;
  logic [2:0]   count_r,    count_nxt;
  logic [31:0]  deadline_r, deadline_nxt;
  logic         level_r,    level_nxt;

  status_t      sel_status;
  pattern_t     cur_pat;
  pattern_t     new_pat;
  logic [31:0]  since;
  logic         reached;
  logic [2:0]   count_inc;
  out_item_t    result;

  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign cfg_ready = 1'b1;

  // Enable register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      enable_r <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_item;
    end
  end

  // Priority status select
  always_comb begin
    priority if (s1_item_r.relay_valid && s1_item_r.relay_alarm) begin
      sel_status = ST_ALARM;
    end else if (s1_item_r.rental_lapsed) begin
      sel_status = ST_LICENSE;
    end else if (s1_item_r.relay_valid && s1_item_r.relay_mode == RLY_ERROR) begin
      sel_status = ST_RLY_ERR;
    end else if (s1_item_r.relay_valid && s1_item_r.relay_mode == RLY_ACTIVE) begin
      sel_status = ST_ACTIVE;
    end else if (s1_item_r.relay_valid && s1_item_r.relay_mode == RLY_WAITING
                 && s1_item_r.relay_synced) begin
      sel_status = ST_WAITING;
    end else if (!s1_item_r.gnss_3d_lock) begin
      sel_status = ST_NOGPS;
    end else begin
      sel_status = ST_IDLE;
    end
  end

  assign cur_pat   = pattern_lookup(status_r);
  assign new_pat   = pattern_lookup(sel_status);
  assign since     = s1_item_r.now_ms - deadline_r;
  assign reached   = !since[31];
  assign count_inc = count_r + 3'd1;

  // Blink machine next state
  always_comb begin
    status_nxt   = status_r;
    phase_nxt    = phase_r;
    count_nxt    = count_r;
    deadline_nxt = deadline_r;
    level_nxt    = level_r;
    if (sel_status != status_r) begin
      // re-arm on status change
      status_nxt   = sel_status;
      phase_nxt    = PH_ON;
      count_nxt    = 3'd0;
      deadline_nxt = new_pat.solid ? DEADLINE_SOLID
                   : s1_item_r.now_ms + {{(32-DUR_W){1'b0}}, new_pat.on_ms};
      level_nxt    = 1'b1;
    end else if (cur_pat.solid) begin
      level_nxt = 1'b1;
    end else if (reached) begin
      unique case (phase_r)
        PH_ON: begin
          level_nxt = 1'b0;
          if (cur_pat.pulses == 3'd0) begin
            phase_nxt    = PH_OFF;
            deadline_nxt = s1_item_r.now_ms + {{(32-DUR_W){1'b0}}, cur_pat.off_ms};
          end else if (count_inc < cur_pat.pulses) begin
            count_nxt    = count_inc;
            phase_nxt    = PH_OFF;
            deadline_nxt = s1_item_r.now_ms + {{(32-DUR_W){1'b0}}, cur_pat.off_ms};
          end else begin
            count_nxt    = 3'd0;
            phase_nxt    = PH_PAUSE;
            deadline_nxt = s1_item_r.now_ms + {{(32-DUR_W){1'b0}}, cur_pat.rest_ms};
          end
        end
        PH_OFF, PH_PAUSE: begin
          if (phase_r == PH_PAUSE) begin
            count_nxt = 3'd0;
          end
          level_nxt    = 1'b1;
          phase_nxt    = PH_ON;
          deadline_nxt = s1_item_r.now_ms + {{(32-DUR_W){1'b0}}, cur_pat.on_ms};
        end
        default: begin
          // unused phase code: hold
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // Result of the update
  always_comb begin
    result.led_on      = level_nxt & enable_r;
    result.status_code = status_nxt;
  end

  // Blink machine state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r   <= ST_IDLE;
      phase_r    <= PH_ON;
      count_r    <= 3'd0;
      deadline_r <= DEADLINE_RST;
      level_r    <= 1'b1;
    end else if (advance) begin
      status_r   <= status_nxt;
      phase_r    <= phase_nxt;
      count_r    <= count_nxt;
      deadline_r <= deadline_nxt;
      level_r    <= level_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

  // LED level is high exactly in the ON phase
  a_level_phase: assert property (@(posedge clk) disable iff (!rst_n)
    level_r == (phase_r == PH_ON))
    else $error("LED level out of step with blink phase");

  // Patterns without bursts never count pulses
  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_pat.pulses == 3'd0) |-> (count_r == 3'd0))
    else $error("pulse count set on a non-burst pattern");

  // Solid pattern parks the deadline
  a_solid_deadline: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r == ST_WAITING) |-> (deadline_r == DEADLINE_SOLID))
    else $error("solid pattern with a live deadline");

  // A held input transaction is not dropped
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("input transaction lost while result stalled");

endmodule

FILE: tb/sv/led_status_blink_controller_test.sv
// Self-checking testbench for the LED status blink controller: directed table, then random traffic.
module led_status_blink_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lsbc_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned NUM_PHASES     = 6;
  localparam int unsigned RAND_PER_PHASE = 325;
  localparam int unsigned DRAIN_CYCLES   = 8;      // two-stage pipe plus margin
  localparam logic [1:0]  RLY_OTHER      = 2'd0;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RAND,
    STALL_TOGGLE,
    STALL_BLOCKS
  } stall_mode_t;

  // One blink pattern: durations in ms
  typedef struct {
    int unsigned on_t;
    int unsigned off_t;
    int unsigned pulses;
    int unsigned pause_t;
    bit          solid;
  } blink_pat_t;

  // One row of the directed table
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } dir_row_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data  = 1'b0;

  // Predicted blink machine state
  status_t     cur_status;
  phase_t      phase;
  logic [2:0]  pulse_cnt;
  logic [31:0] deadline;
  logic        led_lvl;
  logic        led_en;

  out_item_t   expected_leds[$];
  out_item_t   want;
  dir_row_t    dir_rows[$];
  int unsigned fails      = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned burst_left = 0;

  stall_mode_t stall_mode = STALL_NONE;
  logic [6:0]  stall_span = '0;

  led_status_blink_controller i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Pattern ROM per status
  function automatic blink_pat_t pattern_of(input status_t s);
    blink_pat_t p;
    p = '{100, 4900, 0, 0, 1'b0};
    case (s)
      ST_ALARM:   p = '{50, 50, 0, 0, 1'b0};
      ST_LICENSE: p = '{100, 150, 5, 3000, 1'b0};
      ST_RLY_ERR: p = '{200, 200, 3, 2000, 1'b0};
      ST_ACTIVE:  p = '{100, 400, 0, 0, 1'b0};
      ST_WAITING: p = '{0, 0, 0, 0, 1'b1};
      ST_NOGPS:   p = '{600, 1400, 0, 0, 1'b0};
      default:    p = '{100, 4900, 0, 0, 1'b0};
    endcase
    return p;
  endfunction

  // Fixed priority status select
  function automatic status_t status_of(input in_item_t it);
    if (it.relay_valid && it.relay_alarm) return ST_ALARM;
    if (it.rental_lapsed) return ST_LICENSE;
    if (it.relay_valid && it.relay_mode == RLY_ERROR) return ST_RLY_ERR;
    if (it.relay_valid && it.relay_mode == RLY_ACTIVE) return ST_ACTIVE;
    if (it.relay_valid && it.relay_mode == RLY_WAITING && it.relay_synced) return ST_WAITING;
    if (!it.gnss_3d_lock) return ST_NOGPS;
    return ST_IDLE;
  endfunction

  function automatic in_item_t random_flags();
    in_item_t it;
    it.now_ms        = $urandom;
    it.relay_valid   = 1'($urandom_range(0, 1));
    it.relay_alarm   = 1'($urandom_range(0, 1));
    it.relay_mode    = 2'($urandom_range(0, 3));
    it.relay_synced  = 1'($urandom_range(0, 1));
    it.rental_lapsed = 1'($urandom_range(0, 1));
    it.gnss_3d_lock  = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Advance the predicted blink machine by one update transaction
  task automatic blink_update(input in_item_t it, output out_item_t res);
    status_t     s;
    blink_pat_t  p;
    logic [31:0] lag;
    s = status_of(it);
    if (s != cur_status) begin
      // status change re-arms, ignoring any pending deadline
      p          = pattern_of(s);
      cur_status = s;
      pulse_cnt  = '0;
      phase      = PH_ON;
      deadline   = p.solid ? 32'hFFFF_FFFF : it.now_ms + p.on_t;
      led_lvl    = 1'b1;
    end else begin
      p   = pattern_of(cur_status);
      lag = it.now_ms - deadline;
      if (p.solid) begin
        led_lvl = 1'b1;
      end else if (!lag[31]) begin
        case (phase)
          PH_ON: begin
            led_lvl = 1'b0;
            if (p.pulses == 0) begin
              phase    = PH_OFF;
              deadline = it.now_ms + p.off_t;
            end else begin
              pulse_cnt = pulse_cnt + 3'd1;
              if (pulse_cnt < p.pulses) begin
                phase    = PH_OFF;
                deadline = it.now_ms + p.off_t;
              end else begin
                pulse_cnt = '0;
                phase     = PH_PAUSE;
                deadline  = it.now_ms + p.pause_t;
              end
            end
          end
          PH_OFF, PH_PAUSE: begin
            if (phase == PH_PAUSE) pulse_cnt = '0;
            led_lvl  = 1'b1;
            phase    = PH_ON;
            deadline = it.now_ms + p.on_t;
          end
          default: ;
        endcase
      end
    end
    res.led_on      = led_lvl & led_en;
    res.status_code = cur_status;
  endtask

  task automatic add_row(input logic [31:0] now, input logic v, input logic a,
                         input logic [1:0] m, input logic sy, input logic lic,
                         input logic gps, input bit typed, input logic led,
                         input status_t st);
    dir_row_t r;
    r.item                 = '{now, v, a, m, sy, lic, gps};
    r.typed                = typed;
    r.result.led_on        = led;
    r.result.status_code   = st;
    dir_rows.push_back(r);
  endtask

  // Drive one update transaction in sender bursts; queue its expected result
  task automatic send_update(input in_item_t it, input bit typed, input out_item_t fixed);
    out_item_t res;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    blink_update(it, res);
    expected_leds.push_back(typed ? fixed : res);
  endtask

  // Wait until every expected result is out, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_leds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_led_enable(input logic v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    led_en = v;
  endtask

  // Receiver stall patterns, switched each time the random span counter runs out
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_span <= 7'($urandom_range(16, 96));
    end else begin
      stall_span <= stall_span - 7'd1;
    end
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_RAND:   out_stall <= ($urandom_range(0, 3) == 0);
      STALL_TOGGLE: out_stall <= ~out_stall;
      default:      out_stall <= stall_span[3];
    endcase
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_leds.size() == 0) begin
        $error("result transaction with none expected: led_on %0b status_code %0d",
               out_item.led_on, out_item.status_code);
        fails++;
      end else begin
        want = expected_leds.pop_front();
        if (out_item.led_on !== want.led_on) begin
          $error("led_on: expected %0b, actual %0b", want.led_on, out_item.led_on);
          fails++;
        end
        if (out_item.status_code !== want.status_code) begin
          $error("status_code: expected %0d, actual %0d",
                 want.status_code, out_item.status_code);
          fails++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("led_status_blink_controller_test: errors");
      $finish;
    end
  end

  initial begin
    in_item_t    it;
    status_t     target;
    bit          noise_seg;
    int unsigned seg_left;
    int unsigned r;
    logic [31:0] clock_ms;

    seg_left   = 0;
    noise_seg  = 1'b0;
    target     = ST_IDLE;
    clock_ms   = '0;
    cur_status = ST_IDLE;
    phase      = PH_ON;
    pulse_cnt  = '0;
    deadline   = 32'd100;
    led_lvl    = 1'b1;
    led_en     = 1'b1;

    // Directed table: now, valid, alarm, mode, synced, license, gps, typed, led, status
    add_row(32'd0,   0, 0, RLY_OTHER,   0, 0, 1, 1, 1, ST_IDLE);
    add_row(32'd100, 0, 0, RLY_OTHER,   0, 0, 1, 0, 0, ST_IDLE);
    // alarm beats every other condition
    add_row(32'd120, 1, 1, RLY_ERROR,   1, 1, 0, 1, 1, ST_ALARM);
    add_row(32'd170, 1, 1, RLY_ERROR,   1, 1, 0, 0, 0, ST_ALARM);
    add_row(32'd219, 1, 1, RLY_ERROR,   1, 1, 0, 0, 0, ST_ALARM);
    add_row(32'd220, 1, 1, RLY_ERROR,   1, 1, 0, 0, 0, ST_ALARM);
    add_row(32'd230, 1, 0, RLY_ERROR,   1, 1, 0, 1, 1, ST_LICENSE);
    add_row(32'd240, 1, 0, RLY_ERROR,   1, 0, 0, 1, 1, ST_RLY_ERR);
    add_row(32'd250, 1, 0, RLY_ACTIVE,  1, 0, 0, 1, 1, ST_ACTIVE);
    add_row(32'd260, 1, 0, RLY_WAITING, 1, 0, 0, 1, 1, ST_WAITING);
    // solid pattern at the top of the time range
    add_row(32'hFFFF_FFFF, 1, 0, RLY_WAITING, 1, 0, 0, 0, 0, ST_WAITING);
    add_row(32'd0,   1, 0, RLY_WAITING, 0, 0, 0, 1, 1, ST_NOGPS);
    // relay flags ignored without relay_valid
    add_row(32'd10,  0, 1, RLY_ERROR,   1, 0, 1, 1, 1, ST_IDLE);
    add_row(32'd20,  1, 0, RLY_OTHER,   1, 0, 0, 1, 1, ST_NOGPS);
    // deadline wraps past zero
    add_row(32'hFFFF_FFF0, 1, 1, RLY_OTHER, 0, 0, 1, 1, 1, ST_ALARM);
    add_row(32'h0000_0010, 1, 1, RLY_OTHER, 0, 0, 1, 0, 0, ST_ALARM);
    add_row(32'h0000_0030, 1, 1, RLY_OTHER, 0, 0, 1, 0, 0, ST_ALARM);
    // exactly half the range behind is not yet reached, one less is
    add_row(32'h8000_0062, 1, 1, RLY_OTHER, 0, 0, 1, 0, 0, ST_ALARM);
    add_row(32'h8000_0061, 1, 1, RLY_OTHER, 0, 0, 1, 0, 0, ST_ALARM);
    add_row(32'h7FFF_FFFF, 0, 0, RLY_OTHER, 0, 0, 1, 1, 1, ST_IDLE);
    add_row(32'hFFFF_FFFF, 1, 1, RLY_ERROR, 1, 1, 1, 1, 1, ST_ALARM);
    add_row(32'h0000_0000, 0, 0, RLY_OTHER, 0, 0, 0, 1, 1, ST_NOGPS);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_update(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].result);
    clock_ms = 32'd1000;

    // Random phases, each under its own output enable setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 3) write_led_enable(ph[0]);
      else write_led_enable(1'($urandom_range(0, 1)));
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if (seg_left == 0) begin
          noise_seg = ($urandom_range(0, 4) == 0);
          target    = status_t'($urandom_range(0, 6));
          seg_left  = noise_seg ? $urandom_range(1, 8) : $urandom_range(4, 40);
        end
        seg_left--;
        it = random_flags();
        // steady status with random don't-care bits; an occasional glitch breaks it
        if (!noise_seg && $urandom_range(0, 19) != 0) begin
          while (status_of(it) != target) it = random_flags();
        end
        r = $urandom_range(0, 99);
        if (r < 50) clock_ms = clock_ms + $urandom_range(0, 250);
        else if (r < 75) clock_ms = clock_ms + $urandom_range(250, 3200);
        else if (r < 85) clock_ms = deadline + $urandom_range(0, 2) - 32'd1;
        else if (r < 90) clock_ms = deadline + 32'h7FFF_FFFF + $urandom_range(0, 1);
        else if (r < 95) clock_ms = clock_ms;
        else clock_ms = $urandom;
        it.now_ms = clock_ms;
        send_update(it, 1'b0, '0);
      end
    end

    drain();
    if (fails == 0) begin
      $display("led_status_blink_controller_test: clean");
    end else begin
      $display("led_status_blink_controller_test: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/lsbc_pkg.sv
src/led_status_blink_controller.sv
tb/sv/led_status_blink_controller_test.sv
